@@ rtl/ebml_pkg.sv @@
package ebml_pkg;

  localparam int unsigned ValueW = 56;
  localparam int unsigned LenW   = 4;
  localparam int unsigned LeftW  = 3;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_MARKER = 2'd1,
    ST_EARLY_END = 2'd2
  } status_t;

  typedef enum logic {
    KIND_ID   = 1'b0,
    KIND_SIZE = 1'b1
  } kind_t;

endpackage

@@ rtl/ebml_in_if.sv @@
interface ebml_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;
  logic       data_end;

  modport source (output valid, mode, data_byte, data_end, input ready);
  modport sink   (input valid, mode, data_byte, data_end, output ready);
endinterface

@@ rtl/ebml_out_if.sv @@
interface ebml_out_if;
  logic                          valid;
  logic                          ready;
  logic [ebml_pkg::ValueW-1:0]   number_value;
  logic [ebml_pkg::LenW-1:0]     byte_length;
  logic                          size_unknown;
  ebml_pkg::status_t             status;

  modport source (output valid, number_value, byte_length, size_unknown, status,
                  input ready);
  modport sink   (input valid, number_value, byte_length, size_unknown, status,
                  output ready);
endinterface

@@ rtl/ebml_element_header_parser.sv @@
// channel   | dir | payload                                            | handshake
// ----------+-----+----------------------------------------------------+-------------
// in_word   | in  | mode, data_byte, data_end                          | valid/ready
// out_word  | out | number_value, byte_length, size_unknown, status    | valid/ready
//
// one byte a cycle while in_word.ready is high: each accepted word is decoded in
// the cycle it arrives and any result lands in the output register on the same edge
// a word gives at most one result word; the output register is the only buffer
// in_word.ready falls only while a result waits and out_word.ready is low
// rst_n is synchronous, active low: decoder returns to idle, output register empty
module ebml_element_header_parser (
  input  logic       clk,
  input  logic       rst_n,
  ebml_in_if.sink    in_word,
  ebml_out_if.source out_word
);
  import ebml_pkg::*;

  // decoder state, updated on every accepted word
  kind_t             kind_r,     kind_nxt;
  logic [LeftW-1:0]  left_r,     left_nxt;
  logic [LenW-1:0]   total_r,    total_nxt;
  logic [ValueW-1:0] acc_r,      acc_nxt;
  logic              ones_r,     ones_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [ValueW-1:0] out_value_r, out_value_nxt;
  logic [LenW-1:0]   out_len_r,   out_len_nxt;
  logic              out_unk_r,   out_unk_nxt;
  status_t           out_st_r,    out_st_nxt;

  logic              accept;
  logic [LenW-1:0]   first_len;
  logic [7:0]        vmask;
  logic [7:0]        masked;

  // take a new word whenever the output register is free or being emptied
  assign in_word.ready = !out_valid_r || out_word.ready;
  assign accept        = in_word.valid && in_word.ready;

  // length from the first byte's leading marker bit, 0 if none (ids use bits 7..4 only)
  always_comb begin
    first_len = '0;
    if (in_word.data_byte[7])      first_len = LenW'(1);
    else if (in_word.data_byte[6]) first_len = LenW'(2);
    else if (in_word.data_byte[5]) first_len = LenW'(3);
    else if (in_word.data_byte[4]) first_len = LenW'(4);
    else if (in_word.mode == KIND_SIZE) begin
      if (in_word.data_byte[3])      first_len = LenW'(5);
      else if (in_word.data_byte[2]) first_len = LenW'(6);
      else if (in_word.data_byte[1]) first_len = LenW'(7);
      else if (in_word.data_byte[0]) first_len = LenW'(8);
    end
    vmask  = 8'hFF >> first_len;
    masked = in_word.data_byte & vmask;
  end

  always_comb begin
    kind_nxt      = kind_r;
    left_nxt      = left_r;
    total_nxt     = total_r;
    acc_nxt       = acc_r;
    ones_nxt      = ones_r;
    out_valid_nxt = out_valid_r && !out_word.ready;
    out_value_nxt = out_value_r;
    out_len_nxt   = out_len_r;
    out_unk_nxt   = out_unk_r;
    out_st_nxt    = out_st_r;

    if (accept) begin
      if (left_r == '0) begin
        // first byte of a number
        if (first_len == '0) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = '0;
          out_len_nxt   = '0;
          out_unk_nxt   = 1'b0;
          out_st_nxt    = ST_NO_MARKER;
        end else if (first_len == LenW'(1)) begin
          // single byte number completes at once
          out_valid_nxt = 1'b1;
          out_len_nxt   = first_len;
          out_st_nxt    = ST_OK;
          if (in_word.mode == KIND_ID) begin
            out_value_nxt = ValueW'(in_word.data_byte);
            out_unk_nxt   = 1'b0;
          end else begin
            out_value_nxt = ValueW'(masked);
            out_unk_nxt   = (masked == vmask);
          end
        end else if (in_word.data_end) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = '0;
          out_len_nxt   = '0;
          out_unk_nxt   = 1'b0;
          out_st_nxt    = ST_EARLY_END;
        end else begin
          kind_nxt  = kind_t'(in_word.mode);
          total_nxt = first_len;
          left_nxt  = LeftW'(first_len - LenW'(1));
          if (in_word.mode == KIND_ID) begin
            acc_nxt  = ValueW'(in_word.data_byte);
            ones_nxt = 1'b0;
          end else begin
            acc_nxt  = ValueW'(masked);
            ones_nxt = (masked == vmask);
          end
        end
      end else begin
        // continuation byte: shift in and count down
        if (left_r == LeftW'(1)) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = {acc_r[ValueW-9:0], in_word.data_byte};
          out_len_nxt   = total_r;
          out_unk_nxt   = (kind_r == KIND_SIZE) && ones_r && (in_word.data_byte == 8'hFF);
          out_st_nxt    = ST_OK;
          left_nxt      = '0;
        end else if (in_word.data_end) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = '0;
          out_len_nxt   = '0;
          out_unk_nxt   = 1'b0;
          out_st_nxt    = ST_EARLY_END;
          left_nxt      = '0;
        end else begin
          acc_nxt  = {acc_r[ValueW-9:0], in_word.data_byte};
          ones_nxt = ones_r && (in_word.data_byte == 8'hFF);
          left_nxt = left_r - LeftW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r      <= KIND_ID;
      left_r      <= '0;
      total_r     <= '0;
      acc_r       <= '0;
      ones_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      kind_r      <= kind_nxt;
      left_r      <= left_nxt;
      total_r     <= total_nxt;
      acc_r       <= acc_nxt;
      ones_r      <= ones_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload needs no reset
  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_len_r   <= out_len_nxt;
    out_unk_r   <= out_unk_nxt;
    out_st_r    <= out_st_nxt;
  end

  assign out_word.valid        = out_valid_r;
  assign out_word.number_value = out_value_r;
  assign out_word.byte_length  = out_len_r;
  assign out_word.size_unknown = out_unk_r;
  assign out_word.status       = out_st_r;

  // error results carry no number
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_st_r != ST_OK) |-> (out_value_r == '0) && (out_len_r == '0) && !out_unk_r)
    else $error("error result with non-zero payload");

  // good results have a length of one to eight
  a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_st_r == ST_OK) |-> (out_len_r != '0) && (out_len_r <= LenW'(8)))
    else $error("good result with bad length");

  // mid-number the bytes still due are fewer than the total
  a_left_total: assert property (@(posedge clk) disable iff (!rst_n)
    (left_r != '0) |-> (LenW'(left_r) < total_r))
    else $error("bytes left not below total length");

  // a zero first byte of a size always reports a missing marker
  a_zero_size: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (left_r == '0) && (in_word.mode == KIND_SIZE) && (in_word.data_byte == 8'h00)
    |=> out_valid_r && (out_st_r == ST_NO_MARKER))
    else $error("zero size byte not flagged");

endmodule

@@ sim/tb_ebml_element_header_parser.sv @@
`timescale 1ns / 1ps

module tb_ebml_element_header_parser;
  import ebml_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseWords = 100;

  // one decoded number as it leaves the block
  typedef struct packed {
    logic [ValueW-1:0] number_value;
    logic [LenW-1:0]   byte_length;
    logic              size_unknown;
    status_t           status;
  } header_result_t;

  // running copy of the decoder plus the queue of numbers still owed
  class vint_scoreboard;
    kind_t             kind;
    logic [LeftW-1:0]  left;
    logic [LenW-1:0]   total;
    logic [ValueW-1:0] acc;
    bit                ones;
    header_result_t    pending_numbers[$];
    int unsigned       errors;

    function new();
      errors = 0;
      go_idle();
    endfunction

    function void go_idle();
      kind  = KIND_ID;
      left  = '0;
      total = '0;
      acc   = '0;
      ones  = 1'b1;
    endfunction

    // append a result to the tail of the owed queue
    function void queue_result(header_result_t r);
      pending_numbers = {pending_numbers, r};
    endfunction

    function void owe_error(status_t st);
      header_result_t r;
      r        = '0;
      r.status = st;
      queue_result(r);
      go_idle();
    endfunction

    function void owe_number();
      header_result_t r;
      r.number_value = acc;
      r.byte_length  = total;
      r.size_unknown = (kind == KIND_SIZE) ? ones : 1'b0;
      r.status       = ST_OK;
      queue_result(r);
      go_idle();
    endfunction

    // advance the decoder by one accepted byte
    function void note_byte(logic mode, logic [7:0] b, logic last);
      int unsigned len;
      logic [7:0]  vmask;
      if (left == 0) begin
        len = 0;
        for (int i = 0; i < 8; i++)
          if (len == 0 && b[7-i]) len = i + 1;
        if (mode == KIND_ID && len > 4) len = 0;
        if (len == 0) begin
          owe_error(ST_NO_MARKER);
          return;
        end
        kind  = kind_t'(mode);
        total = LenW'(len);
        vmask = 8'hFF >> len;
        if (kind == KIND_ID) begin
          acc  = ValueW'(b);
          ones = 1'b0;
        end else begin
          acc  = ValueW'(b & vmask);
          ones = ((b & vmask) == vmask);
        end
        if (len == 1) owe_number();
        else if (last) owe_error(ST_EARLY_END);
        else left = LeftW'(len - 1);
      end else begin
        acc = {acc[ValueW-9:0], b};
        if (b != 8'hFF) ones = 1'b0;
        left = left - LeftW'(1);
        if (left == 0) owe_number();
        else if (last) owe_error(ST_EARLY_END);
      end
    endfunction

    function void check_result(header_result_t got);
      header_result_t want;
      if (pending_numbers.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result value=%h len=%0d unk=%b st=%0d",
                   $realtime, got.number_value, got.byte_length, got.size_unknown,
                   got.status);
        return;
      end
      want = pending_numbers.pop_front();
      if (got.number_value !== want.number_value || got.byte_length !== want.byte_length ||
          got.size_unknown !== want.size_unknown || got.status !== want.status) begin
        errors++;
        if (errors <= 10)
          $display({"%0t: mismatch exp value=%h len=%0d unk=%b st=%0d,",
                    " got value=%h len=%0d unk=%b st=%0d"},
                   $realtime, want.number_value, want.byte_length, want.size_unknown,
                   want.status, got.number_value, got.byte_length, got.size_unknown,
                   got.status);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  ebml_in_if  in_ch ();
  ebml_out_if out_ch ();

  ebml_element_header_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_ch),
    .out_word (out_ch)
  );

  vint_scoreboard sb = new();

  int unsigned words_sent;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned cycles;

  // free-running clock, 10 ns period
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // known values on every input before reset lifts
  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = 1'b0;
    in_ch.data_byte   = 8'h00;
    in_ch.data_end    = 1'b0;
    out_ch.ready      = 1'b1;
    send_idle_pct     = 0;
    stall_pct         = 0;
    words_sent        = 0;
    cycles            = 0;
  end

  // receiver back-pressure, changed away from the sampling edge
  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= stall_pct);
  end

  // result monitor: values read at the rising edge before any flop updates
  always @(posedge clk) begin
    header_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.number_value = out_ch.number_value;
      got.byte_length  = out_ch.byte_length;
      got.size_unknown = out_ch.size_unknown;
      got.status       = out_ch.status;
      sb.check_result(got);
    end
  end

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // drive one byte word, holding it until the block takes it
  task automatic send_byte(logic mode, logic [7:0] b, logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.mode      = mode;
    in_ch.data_byte = b;
    in_ch.data_end  = last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_byte(mode, b, last);
    words_sent++;
  endtask

  // a well-formed number of len bytes; cut_at > 0 raises data_end early on that byte
  task automatic send_number(logic mode, int unsigned len, int unsigned cut_at,
                             logic tail_end, bit fill_ones);
    logic [7:0] first;
    logic [7:0] b;
    logic       m;
    logic       e;
    first = 8'($urandom);
    first = (first & (8'hFF >> len)) | (8'h80 >> (len - 1));
    if (fill_ones) first = first | (8'hFF >> len);
    for (int unsigned i = 0; i < len; i++) begin
      b = (i == 0) ? first : (fill_ones ? 8'hFF : 8'($urandom));
      // mode after the first byte is noise the block must ignore
      m = (i == 0) ? mode : 1'($urandom_range(1));
      e = (cut_at == i + 1) || (i == len - 1 && tail_end);
      send_byte(m, b, e);
      if (cut_at == i + 1) break;
    end
  endtask

  task automatic random_phase(int unsigned target);
    logic        mode;
    int unsigned len;
    int unsigned cut;
    while (words_sent < target) begin
      if ($urandom_range(99) < 15) begin
        // stray byte: random kind, random end flag
        send_byte(1'($urandom_range(1)), 8'($urandom), 1'($urandom_range(1)));
      end else begin
        mode = 1'($urandom_range(1));
        len  = (mode == KIND_SIZE) ? $urandom_range(1, 8) : $urandom_range(1, 4);
        cut  = (len > 1 && $urandom_range(9) == 0) ? $urandom_range(1, len - 1) : 0;
        send_number(mode, len, cut, 1'($urandom_range(1)), $urandom_range(4) == 0);
      end
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // directed words, no idling
    send_byte(KIND_ID, 8'hFF, 1'b0);          // widest one-byte id
    send_byte(KIND_ID, 8'h80, 1'b1);          // end flag on the completing byte
    send_byte(KIND_ID, 8'h40, 1'b0);
    send_byte(KIND_ID, 8'h00, 1'b0);
    send_byte(KIND_ID, 8'h1A, 1'b0);          // four-byte id
    send_byte(KIND_ID, 8'h45, 1'b0);
    send_byte(KIND_ID, 8'hDF, 1'b0);
    send_byte(KIND_ID, 8'hA3, 1'b0);
    send_byte(KIND_ID, 8'h0F, 1'b0);          // id without marker
    send_byte(KIND_ID, 8'h00, 1'b1);          // no marker wins over end flag
    send_byte(KIND_SIZE, 8'h00, 1'b0);        // size without marker
    send_byte(KIND_SIZE, 8'hFF, 1'b0);        // one-byte unknown size
    send_byte(KIND_SIZE, 8'h01, 1'b0);        // eight-byte unknown size
    repeat (7) send_byte(KIND_SIZE, 8'hFF, 1'b0);
    send_byte(KIND_SIZE, 8'h40, 1'b1);        // data ends on the first byte
    send_byte(KIND_ID, 8'h20, 1'b0);          // data ends mid id
    send_byte(KIND_ID, 8'h11, 1'b1);
    send_byte(KIND_SIZE, 8'h7F, 1'b0);        // kind latched, later mode ignored
    send_byte(KIND_ID, 8'hFF, 1'b0);

    // random traffic under four idling patterns
    random_phase(PhaseWords);
    send_idle_pct = 64;
    stall_pct     = 0;
    random_phase(2 * PhaseWords);
    send_idle_pct = 0;
    stall_pct     = 64;
    random_phase(3 * PhaseWords);
    send_idle_pct = 21;
    stall_pct     = 21;
    random_phase(4 * PhaseWords);

    @(negedge clk);
    in_ch.valid = 1'b0;

    // drain, then allow stray late results to show up
    while (sb.pending_numbers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (sb.errors == 0 && sb.pending_numbers.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
